/* hdl/ihc_pkg.sv */
// Package for the IPv4 header check and classifier.
// Holds the packet summary record, verdict and class codes, header offsets
// and the one's complement add. No dependencies.
package ihc_pkg;

  localparam int QueueDepth = 4;
  localparam int QueueAddrW = $clog2(QueueDepth);

  localparam logic [15:0] MinHeader = 16'd20;
  localparam logic [15:0] WordMask = 16'hFFFF;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;
  localparam logic [7:0] LastOctetMask = 8'hFF;
  localparam logic [3:0] IpVersion4 = 4'd4;

  localparam logic [15:0] OffVersionIhl = 16'd0;
  localparam logic [15:0] OffTotalLenHi = 16'd2;
  localparam logic [15:0] OffTotalLenLo = 16'd3;
  localparam logic [15:0] OffProtocol = 16'd9;
  localparam logic [15:0] OffChecksumHi = 16'd10;
  localparam logic [15:0] OffChecksumLo = 16'd11;
  localparam logic [13:0] SourceWord = 14'd3;
  localparam logic [13:0] DestWord = 14'd4;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [7:0] ProtoTcp = 8'd6;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT = 3'd0,
    VERDICT_TOO_SHORT = 3'd1,
    VERDICT_BAD_VERSION = 3'd2,
    VERDICT_BAD_HLEN = 3'd3,
    VERDICT_BAD_CHECKSUM = 3'd4,
    VERDICT_NOT_OURS = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    CLASS_ICMP = 2'd0,
    CLASS_UDP = 2'd1,
    CLASS_TCP = 2'd2,
    CLASS_OTHER = 2'd3
  } proto_class_t;

  typedef struct packed {
    logic [7:0] version_ihl;
    logic [15:0] tot_len;
    logic [7:0] protocol;
    logic [15:0] stored_checksum;
    logic [31:0] source;
    logic [31:0] dest;
    logic [15:0] running_sum;
    logic [15:0] byte_count;
  } pkt_rec_t;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic proto_class_t class_of(input logic [7:0] proto);
    proto_class_t c;
    priority if (proto == ProtoIcmp) c = CLASS_ICMP;
    else if (proto == ProtoUdp) c = CLASS_UDP;
    else if (proto == ProtoTcp) c = CLASS_TCP;
    else c = CLASS_OTHER;
    return c;
  endfunction

endpackage

/* hdl/ihc_front.sv */
// Front end of the IPv4 header check: takes packet bytes, captures header
// fields and folds the header checksum, then hands a summary record to the
// queue on the last byte. Depends on ihc_pkg.
module ihc_front import ihc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_packet,
  input  logic       queue_full,
  output logic       push,
  output pkt_rec_t   push_rec
);

  logic [15:0] byte_position, byte_position_next;
  logic [7:0] version_ihl, version_ihl_next;
  logic [15:0] tot_len, tot_len_next;
  logic [7:0] protocol, protocol_next;
  logic [15:0] stored_checksum, stored_checksum_next;
  logic [31:0] source, source_next;
  logic [31:0] dest, dest_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0] high_byte_hold, high_byte_hold_next;
  logic [5:0] hdr_len;
  logic in_header;
  logic [7:0] sum_byte;
  logic accept;

  assign in_ready = !queue_full;
  assign accept = in_valid && in_ready;
  assign push = accept && end_of_packet;

  always_comb begin
    version_ihl_next = version_ihl;
    tot_len_next = tot_len;
    protocol_next = protocol;
    stored_checksum_next = stored_checksum;
    source_next = source;
    dest_next = dest;
    running_sum_next = running_sum;
    high_byte_hold_next = high_byte_hold;

    if (byte_position == OffVersionIhl) version_ihl_next = data_byte;
    if (byte_position == OffTotalLenHi) tot_len_next[15:8] = data_byte;
    if (byte_position == OffTotalLenLo) tot_len_next[7:0] = data_byte;
    if (byte_position == OffProtocol) protocol_next = data_byte;
    if (byte_position == OffChecksumHi) stored_checksum_next[15:8] = data_byte;
    if (byte_position == OffChecksumLo) stored_checksum_next[7:0] = data_byte;
    if (byte_position[15:2] == SourceWord) begin
      source_next[{byte_position[1:0], 3'b000} +: 8] = data_byte;
    end
    if (byte_position[15:2] == DestWord) begin
      dest_next[{byte_position[1:0], 3'b000} +: 8] = data_byte;
    end

    hdr_len = {version_ihl_next[3:0], 2'b00};
    in_header = ({10'd0, hdr_len} > byte_position) || (byte_position == OffVersionIhl);
    sum_byte = (byte_position == OffChecksumHi || byte_position == OffChecksumLo) ?
               8'd0 : data_byte;
    if (in_header) begin
      if (!byte_position[0]) begin
        high_byte_hold_next = sum_byte;
      end else begin
        running_sum_next = ones_add(running_sum, {high_byte_hold, sum_byte});
      end
    end

    byte_position_next = (byte_position != WordMask) ? byte_position + 16'd1 : byte_position;

    push_rec.version_ihl = version_ihl_next;
    push_rec.tot_len = tot_len_next;
    push_rec.protocol = protocol_next;
    push_rec.stored_checksum = stored_checksum_next;
    push_rec.source = source_next;
    push_rec.dest = dest_next;
    push_rec.running_sum = running_sum_next;
    push_rec.byte_count = byte_position_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_position <= '0;
      version_ihl <= '0;
      tot_len <= '0;
      protocol <= '0;
      stored_checksum <= '0;
      source <= '0;
      dest <= '0;
      running_sum <= '0;
      high_byte_hold <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      version_ihl <= version_ihl_next;
      tot_len <= tot_len_next;
      protocol <= protocol_next;
      stored_checksum <= stored_checksum_next;
      source <= source_next;
      dest <= dest_next;
      running_sum <= running_sum_next;
      high_byte_hold <= high_byte_hold_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    push |=> (byte_position == '0 && running_sum == '0 && version_ihl == '0))
    else $error("packet state not cleared after last byte");
`endif

endmodule

/* hdl/ihc_queue.sv */
// Short queue of packet summary records between the front and back ends.
// Flip-flop storage, one write and one read position. Depends on ihc_pkg.
module ihc_queue import ihc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  pkt_rec_t push_rec,
  output logic     full,
  output logic     head_valid,
  output pkt_rec_t head,
  input  logic     pop
);

  pkt_rec_t entries [QueueDepth];
  logic [QueueAddrW-1:0] wr_ptr;
  logic [QueueAddrW-1:0] rd_ptr;
  logic [QueueAddrW:0] count;

  assign full = (count == (QueueAddrW+1)'(QueueDepth));
  assign head_valid = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");
`endif

endmodule

/* hdl/ihc_back.sv */
// Back end of the IPv4 header check: judges one packet summary record per
// cycle, unless stalled, on lengths, version, checksum and own address, and
// holds the result in an output register. Depends on ihc_pkg.
module ihc_back import ihc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        head_valid,
  input  pkt_rec_t    head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  verdict,
  output logic [1:0]  protocol_class,
  output logic [5:0]  header_length,
  output logic [15:0] payload_length,
  output logic [31:0] source_address,
  output logic [31:0] dest_address
);

  logic [31:0] own_address;
  verdict_t verdict_next;
  logic [5:0] hdr_len;
  logic [15:0] hdr_len16;
  logic [15:0] length_diff;
  logic [15:0] avail;
  logic [15:0] payload;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    hdr_len = {head.version_ihl[3:0], 2'b00};
    hdr_len16 = {10'd0, hdr_len};
    length_diff = head.tot_len - hdr_len16;
    avail = head.byte_count - hdr_len16;
    payload = (length_diff > avail) ? avail : length_diff;

    priority if (head.byte_count < MinHeader) verdict_next = VERDICT_TOO_SHORT;
    else if (head.version_ihl[7:4] != IpVersion4) verdict_next = VERDICT_BAD_VERSION;
    else if (hdr_len16 < MinHeader || hdr_len16 > head.byte_count) begin
      verdict_next = VERDICT_BAD_HLEN;
    end else if (head.stored_checksum != '0 && ~head.running_sum != head.stored_checksum) begin
      verdict_next = VERDICT_BAD_CHECKSUM;
    end else if (head.dest != own_address && head.dest != AllOnes &&
                 head.dest[31:24] != LastOctetMask) begin
      verdict_next = VERDICT_NOT_OURS;
    end else verdict_next = VERDICT_ACCEPT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_write) begin
      own_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict <= verdict_next;
      if (verdict_next == VERDICT_ACCEPT) begin
        protocol_class <= class_of(head.protocol);
        header_length <= hdr_len;
        payload_length <= payload;
        source_address <= head.source;
        dest_address <= head.dest;
      end else begin
        protocol_class <= '0;
        header_length <= '0;
        payload_length <= '0;
        source_address <= '0;
        dest_address <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_reject_zeroed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict != VERDICT_ACCEPT) |->
      (protocol_class == '0 && header_length == '0 && payload_length == '0 &&
       source_address == '0 && dest_address == '0))
    else $error("rejected packet carries nonzero fields");
  a_accept_hdr_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict == VERDICT_ACCEPT) |-> ({10'd0, header_length} >= MinHeader))
    else $error("accepted packet with short header");
`endif

endmodule

/* hdl/ipv4_header_check_classify.sv */
// Top level of the IPv4 receive header check and classifier.
// Instantiates ihc_front, ihc_queue and ihc_back; types from ihc_pkg.
//
// Packet bytes enter on the input channel (in_valid, in_ready, data_byte,
// end_of_packet) in wire order, one byte per cycle at full rate. Each packet
// yields exactly one transaction on the output channel (out_valid, out_ready)
// carrying the verdict and, on acceptance, the protocol class, header length,
// clamped payload length and both addresses; rejected packets carry zeros.
// A packet's result follows its last accepted byte: the front end folds the
// byte into a summary record that enters a four-entry queue, and the back
// end judges one record per cycle, unless stalled, into the output register.
// The sustained rate is one byte per cycle, and one result per cycle for
// back-to-back one-byte packets, given a ready receiver. When the receiver
// stalls, the output register and the queue fill; in_ready drops only once
// the queue holds four pending records. The user must write the own address
// (cfg_write, cfg_data) only while idle; the block does not enforce this.
// Synchronous reset clears the packet state, the queue and the own address.
module ipv4_header_check_classify import ihc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_packet,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  verdict,
  output logic [1:0]  protocol_class,
  output logic [5:0]  header_length,
  output logic [15:0] payload_length,
  output logic [31:0] source_address,
  output logic [31:0] dest_address
);

  logic queue_full;
  logic push;
  pkt_rec_t push_rec;
  logic head_valid;
  pkt_rec_t head;
  logic pop;

  ihc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_packet (end_of_packet),
    .queue_full    (queue_full),
    .push          (push),
    .push_rec      (push_rec)
  );

  ihc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  ihc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .verdict        (verdict),
    .protocol_class (protocol_class),
    .header_length  (header_length),
    .payload_length (payload_length),
    .source_address (source_address),
    .dest_address   (dest_address)
  );

endmodule
